// ----- rtl/thk_pkg.sv -----
package thk_pkg;

    localparam int KEY_W  = 6;
    localparam int WIN_W  = 16;
    localparam int TIME_W = 32;
    localparam int CIDX_W = 2;

    // Register indexes on the configuration channel
    localparam logic [CIDX_W-1:0] REG_HOLD   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_GAP    = 2'd1;
    localparam logic [CIDX_W-1:0] REG_SECOND = 2'd2;

    localparam logic [WIN_W-1:0] HOLD_RESET   = 16'd200;
    localparam logic [WIN_W-1:0] GAP_RESET    = 16'd50;
    localparam logic [WIN_W-1:0] SECOND_RESET = 16'd150;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_TAP     = 3'd1,
        MODE_HOLD    = 3'd2,
        MODE_GAP     = 3'd3,
        MODE_WAIT2   = 3'd4,
        MODE_TAPHOLD = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        PRESS_RELEASE,
        PRESS_DOWN,
        PRESS_NONE
    } press_t;

    typedef enum logic [1:0] {
        DL_KEEP,
        DL_HOLD,
        DL_GAP,
        DL_SECOND
    } dl_sel_t;

    typedef struct packed {
        mode_t   to;
        dl_sel_t dl;
    } next_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVENT,
        ST_SCAN,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic ev_exec;
        logic scan_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic moved;
        logic pend_valid;
        logic scan_last;
    } sts_t;

endpackage

// ----- rtl/thk_ctrl.sv -----
module thk_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_tick,
    output logic          in_ready,
    input  thk_pkg::sts_t sts,
    output thk_pkg::cmd_t cmd
);
    import thk_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = in_tick ? ST_SCAN : ST_EVENT;
                end
            end
            ST_EVENT:
            begin
                if (sts.out_free)
                begin
                    cmd.ev_exec = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                // a move with a result still pending needs room downstream
                if (!(sts.moved && sts.pend_valid && !sts.out_free))
                begin
                    cmd.scan_step = 1'b1;
                    if (sts.scan_last)
                        state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/thk_datapath.sv -----
module thk_datapath #(
    parameter int KEY_COUNT = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  thk_pkg::cmd_t               cmd,
    output thk_pkg::sts_t               sts,
    input  logic                        in_tick,
    input  logic [thk_pkg::KEY_W-1:0]   in_key,
    input  logic                        in_press,
    input  logic                        in_kind,
    input  logic                        cfg_valid,
    input  logic [thk_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [thk_pkg::WIN_W-1:0]   cfg_data,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [thk_pkg::KEY_W-1:0]   out_key,
    output logic                        out_moved,
    output logic [2:0]                  out_from,
    output logic [2:0]                  out_to,
    output logic                        out_last
);
    import thk_pkg::*;

    localparam int IDX_W = $clog2(KEY_COUNT);
    localparam logic [KEY_W:0]   KEY_LIMIT = (KEY_W+1)'(KEY_COUNT);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(KEY_COUNT - 1);

    function automatic next_t key_next(mode_t m, logic th, press_t p, logic exp);
        next_t r;
        r.to = m;
        r.dl = DL_KEEP;
        if (!th)
        begin
            if (m == MODE_IDLE && p == PRESS_DOWN)
                r.to = MODE_TAP;
            else if (m == MODE_TAP && p == PRESS_RELEASE)
                r.to = MODE_IDLE;
        end
        else
        begin
            case (m)
                MODE_IDLE:
                    if (p == PRESS_DOWN)
                    begin
                        r.to = MODE_TAP;
                        r.dl = DL_HOLD;
                    end
                MODE_TAP:
                    if (exp)
                        r.to = MODE_HOLD;
                    else if (p == PRESS_RELEASE)
                    begin
                        r.to = MODE_GAP;
                        r.dl = DL_GAP;
                    end
                MODE_HOLD:
                    if (p == PRESS_RELEASE)
                        r.to = MODE_IDLE;
                MODE_GAP:
                    if (p == PRESS_DOWN)
                        r.to = MODE_TAPHOLD;
                    else if (exp)
                    begin
                        r.to = MODE_WAIT2;
                        r.dl = DL_SECOND;
                    end
                MODE_WAIT2:
                    if (exp)
                        r.to = MODE_IDLE;
                    else if (p == PRESS_DOWN)
                        r.to = MODE_TAPHOLD;
                MODE_TAPHOLD:
                    if (p == PRESS_RELEASE)
                        r.to = MODE_IDLE;
                default:
                    r.to = m;
            endcase
        end
        return r;
    endfunction

    // config and time
    logic [WIN_W-1:0]  hold_win_reg;
    logic [WIN_W-1:0]  gap_win_reg;
    logic [WIN_W-1:0]  second_win_reg;
    logic [TIME_W-1:0] now_reg;

    // latched item
    logic              tick_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              press_reg;
    logic              kind_reg;
    logic [IDX_W-1:0]  idx_reg;

    // per-key store
    logic [KEY_COUNT-1:0] vld_reg;
    mode_t             mem_mode [KEY_COUNT];
    logic              mem_kind [KEY_COUNT];
    logic [TIME_W-1:0] mem_dl   [KEY_COUNT];
    mode_t             rd_mode_reg;
    logic              rd_kind_reg;
    logic              rd_vld_reg;
    logic [TIME_W-1:0] rd_dl_reg;

    // pending scan result and output register
    logic              pend_valid_reg;
    logic [KEY_W-1:0]  pend_key_reg;
    mode_t             pend_from_reg;
    mode_t             pend_to_reg;
    logic              out_valid_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic              out_moved_reg;
    mode_t             out_from_reg;
    mode_t             out_to_reg;
    logic              out_last_reg;

    mode_t             cur_mode;
    logic              cur_kind;
    logic              th_kind;
    press_t            press_code;
    logic [TIME_W-1:0] dl_diff;
    logic              expired;
    next_t             nxt;
    logic              moved;
    logic [WIN_W-1:0]  win_sel;
    logic [TIME_W-1:0] dl_new;
    logic              key_oob;
    logic              in_oob;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic              out_free;
    logic              scan_last;

    always_comb
    begin
        cur_mode   = rd_vld_reg ? rd_mode_reg : MODE_IDLE;
        cur_kind   = rd_vld_reg ? rd_kind_reg : 1'b0;
        // kind is taken from the event only while the key is idle
        th_kind    = (!tick_reg && cur_mode == MODE_IDLE) ? kind_reg : cur_kind;
        press_code = tick_reg ? PRESS_NONE : (press_reg ? PRESS_DOWN : PRESS_RELEASE);
        dl_diff    = now_reg - rd_dl_reg;
        expired    = (|dl_diff) && !dl_diff[TIME_W-1];
        nxt        = key_next(cur_mode, th_kind, press_code, expired);
        moved      = (nxt.to != cur_mode);
        case (nxt.dl)
            DL_HOLD: win_sel = hold_win_reg;
            DL_GAP:  win_sel = gap_win_reg;
            default: win_sel = second_win_reg;
        endcase
        dl_new    = now_reg + TIME_W'(win_sel);
        key_oob   = ({1'b0, key_reg} >= KEY_LIMIT);
        in_oob    = ({1'b0, in_key} >= KEY_LIMIT);
        scan_last = (idx_reg == IDX_LAST);
        out_free  = !out_valid_reg || out_ready;
        wr_idx    = tick_reg ? idx_reg : (key_oob ? '0 : key_reg[IDX_W-1:0]);
        wr_en     = (cmd.ev_exec && !key_oob) || (cmd.scan_step && moved);
        if (cmd.accept)
            rd_addr = (in_tick || in_oob) ? '0 : in_key[IDX_W-1:0];
        else if (cmd.scan_step)
            rd_addr = scan_last ? '0 : idx_reg + IDX_W'(1);
        else
            rd_addr = wr_idx;
    end

    always_comb
    begin
        sts.out_free   = out_free;
        sts.moved      = moved;
        sts.pend_valid = pend_valid_reg;
        sts.scan_last  = scan_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_win_reg   <= HOLD_RESET;
            gap_win_reg    <= GAP_RESET;
            second_win_reg <= SECOND_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOLD:   hold_win_reg   <= cfg_data;
                REG_GAP:    gap_win_reg    <= cfg_data;
                REG_SECOND: second_win_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg        <= '0;
            tick_reg       <= 1'b0;
            idx_reg        <= '0;
            vld_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                tick_reg <= in_tick;
                idx_reg  <= '0;
                if (in_tick)
                    now_reg <= now_reg + TIME_W'(1);
            end
            if (cmd.scan_step)
                idx_reg <= scan_last ? '0 : idx_reg + IDX_W'(1);
            if (wr_en)
                vld_reg[wr_idx] <= 1'b1;
            if (cmd.scan_step && moved)
                pend_valid_reg <= 1'b1;
            else if (cmd.flush)
                pend_valid_reg <= 1'b0;
            if (cmd.ev_exec || cmd.flush || (cmd.scan_step && moved && pend_valid_reg))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            key_reg   <= in_key;
            press_reg <= in_press;
            kind_reg  <= in_kind;
        end
        if (cmd.scan_step && moved)
        begin
            pend_key_reg  <= KEY_W'(idx_reg);
            pend_from_reg <= cur_mode;
            pend_to_reg   <= nxt.to;
        end
        if (cmd.ev_exec)
        begin
            out_key_reg   <= key_reg;
            out_moved_reg <= !key_oob && moved;
            out_from_reg  <= key_oob ? MODE_IDLE : cur_mode;
            out_to_reg    <= key_oob ? MODE_IDLE : nxt.to;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.scan_step && moved && pend_valid_reg)
        begin
            out_key_reg   <= pend_key_reg;
            out_moved_reg <= 1'b1;
            out_from_reg  <= pend_from_reg;
            out_to_reg    <= pend_to_reg;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_key_reg   <= pend_valid_reg ? pend_key_reg : '0;
            out_moved_reg <= pend_valid_reg;
            out_from_reg  <= pend_valid_reg ? pend_from_reg : MODE_IDLE;
            out_to_reg    <= pend_valid_reg ? pend_to_reg : MODE_IDLE;
            out_last_reg  <= 1'b1;
        end
    end

    // key store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_mode[wr_idx] <= nxt.to;
            mem_kind[wr_idx] <= th_kind;
            if (nxt.dl != DL_KEEP)
                mem_dl[wr_idx] <= dl_new;
        end
        rd_mode_reg <= mem_mode[rd_addr];
        rd_kind_reg <= mem_kind[rd_addr];
        rd_dl_reg   <= mem_dl[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_moved = out_moved_reg;
    assign out_from  = out_from_reg;
    assign out_to    = out_to_reg;
    assign out_last  = out_last_reg;

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.ev_exec, cmd.scan_step, cmd.flush}))
        else $error("more than one datapath command");

    a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !pend_valid_reg)
        else $error("scan result left pending at new item");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && moved && pend_valid_reg) |-> out_free)
        else $error("pending result pushed into a full output register");

    a_moved_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_moved_reg) |-> (out_from_reg != out_to_reg))
        else $error("moved result with equal states");
`endif

endmodule

// ----- rtl/tap_hold_key_recognizer_top.sv -----
// Tap-hold key recognizer.
// Input stream (s_axis_*): one beat per item. tuser = 0 is a key event
// (key index, press/release, machine kind); tuser = 1 is a one-ms tick.
// Output stream (m_axis_*): result beats; tlast marks the final beat of
// the item. An event gives exactly one beat; a tick gives one beat per
// expired tap-hold key, or a single "no move" beat if none expired.
// Config channel (cfg_*): 0 hold window, 1 gap window, 2 second-tap
// window, in ms; always ready, to be written only while the block idles.
// Timing: an event reads its key from the store, then loads its result
// register once that register is free. A tick walks the key store one key
// per cycle through a single memory read port, then loads its last beat
// in a flush step once the result register is free. One item is worked
// at a time; s_axis_tready is high only between items.
// A stalled receiver holds the result register; the walk pauses only when
// it finds a move while an earlier one is pending and one still waits there,
// and an event or the end of a walk waits for the result register to free up.
// Reset: all keys idle and basic, ms counter zero, windows 200/50/150.
// Deadlines need no clearing: they are read only after being written.
module tap_hold_key_recognizer_top #(
    parameter int KEY_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [5:0] key_index, [6] pressed, [7] machine_kind
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] key_id, [6] moved, [9:7] from_state,
                                        // [12:10] to_state, [15:13] zero
    output logic        m_axis_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import thk_pkg::*;

    cmd_t             cmd;
    sts_t             sts;
    logic [KEY_W-1:0] out_key;
    logic             out_moved;
    logic [2:0]       out_from;
    logic [2:0]       out_to;

    // register writes never stall
    assign cfg_ready = 1'b1;

    thk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_tick  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    thk_datapath #(
        .KEY_COUNT (KEY_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_tick   (s_axis_tuser[0]),
        .in_key    (s_axis_tdata[5:0]),
        .in_press  (s_axis_tdata[6]),
        .in_kind   (s_axis_tdata[7]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_key   (out_key),
        .out_moved (out_moved),
        .out_from  (out_from),
        .out_to    (out_to),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_to, out_from, out_moved, out_key};

endmodule

// ----- tb/thk_tb_pkg.sv -----
package thk_tb_pkg;

    import thk_pkg::*;

    // s_axis_tuser: what the beat carries
    localparam logic [0:0] ITEM_KEY  = 1'b0;
    localparam logic [0:0] ITEM_TICK = 1'b1;

    // machine kind bit of a key event
    localparam logic KIND_BASIC    = 1'b0;
    localparam logic KIND_TAP_HOLD = 1'b1;

    // s_axis_tdata of a key event, lowest bit last in the list
    typedef struct packed {
        logic             kind;
        logic             pressed;
        logic [KEY_W-1:0] key_index;
    } key_beat_t;

endpackage

// ----- tb/thk_checker.sv -----
module thk_checker
    import thk_pkg::*;
    import thk_tb_pkg::*;
#(
    parameter int KEY_COUNT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          outstanding
);

    // result beat as {tdata, tlast}
    typedef struct packed {
        logic [2:0]       pad;
        logic [2:0]       to_st;
        logic [2:0]       from_st;
        logic             moved;
        logic [KEY_W-1:0] key_id;
        logic             last;
    } result_beat_t;

    mode_t             key_mode [KEY_COUNT];
    logic              key_th   [KEY_COUNT];
    logic [TIME_W-1:0] key_due  [KEY_COUNT];
    logic [TIME_W-1:0] ms_now;
    logic [WIN_W-1:0]  hold_win;
    logic [WIN_W-1:0]  gap_win;
    logic [WIN_W-1:0]  second_win;

    result_beat_t      transitions_q [$];

    // deadline passed: difference nonzero and in the lower half of the range
    function automatic logic due_passed(input int k);
        logic [TIME_W-1:0] d;
        d = ms_now - key_due[k];
        return (d != '0) && !d[TIME_W-1];
    endfunction

    function automatic mode_t tap_hold_move(input int k, input press_t p);
        mode_t m;
        m = key_mode[k];
        case (m)
            MODE_IDLE:
            begin
                if (p == PRESS_DOWN)
                begin
                    key_due[k] = ms_now + TIME_W'(hold_win);
                    return MODE_TAP;
                end
            end
            MODE_TAP:
            begin
                if (due_passed(k))
                    return MODE_HOLD;
                if (p == PRESS_RELEASE)
                begin
                    key_due[k] = ms_now + TIME_W'(gap_win);
                    return MODE_GAP;
                end
            end
            MODE_HOLD, MODE_TAPHOLD:
            begin
                if (p == PRESS_RELEASE)
                    return MODE_IDLE;
            end
            MODE_GAP:
            begin
                if (p == PRESS_DOWN)
                    return MODE_TAPHOLD;
                if (due_passed(k))
                begin
                    key_due[k] = ms_now + TIME_W'(second_win);
                    return MODE_WAIT2;
                end
            end
            MODE_WAIT2:
            begin
                if (due_passed(k))
                    return MODE_IDLE;
                if (p == PRESS_DOWN)
                    return MODE_TAPHOLD;
            end
            default: ;
        endcase
        return m;
    endfunction

    task automatic predict_transitions(input logic [0:0] func, input key_beat_t ev);
        int           k;
        mode_t        m0;
        mode_t        m1;
        result_beat_t held;
        logic         have;
        held = '0;
        have = 1'b0;
        if (func == ITEM_TICK)
        begin
            ms_now = ms_now + TIME_W'(1);
            for (k = 0; k < KEY_COUNT; k++)
            begin
                m0 = key_mode[k];
                if (key_th[k] && (m0 == MODE_TAP || m0 == MODE_GAP || m0 == MODE_WAIT2))
                begin
                    m1 = tap_hold_move(k, PRESS_NONE);
                    if (m1 != m0)
                    begin
                        key_mode[k] = m1;
                        if (have)
                            transitions_q.push_back(held);
                        held         = '0;
                        held.key_id  = k[KEY_W-1:0];
                        held.moved   = 1'b1;
                        held.from_st = m0;
                        held.to_st   = m1;
                        have         = 1'b1;
                    end
                end
            end
        end
        else
        begin
            k = int'(ev.key_index);
            held.key_id = ev.key_index;
            // out-of-range key: ignored, reported as idle with no move
            if (k < KEY_COUNT)
            begin
                m0 = key_mode[k];
                if (m0 == MODE_IDLE)
                    key_th[k] = ev.kind;
                if (!key_th[k])
                begin
                    m1 = m0;
                    if (m0 == MODE_IDLE && ev.pressed)
                        m1 = MODE_TAP;
                    else if (m0 == MODE_TAP && !ev.pressed)
                        m1 = MODE_IDLE;
                end
                else
                    m1 = tap_hold_move(k, ev.pressed ? PRESS_DOWN : PRESS_RELEASE);
                key_mode[k]  = m1;
                held.moved   = (m1 != m0);
                held.from_st = m0;
                held.to_st   = m1;
            end
        end
        held.last = 1'b1;
        transitions_q.push_back(held);
    endtask

    task automatic report(input string what, input result_beat_t want,
                          input result_beat_t got);
        mismatches++;
        $display("%0t %s: expected key %0d moved %0b from %0d to %0d last %0b pad %0d",
                 $time, what, want.key_id, want.moved, want.from_st, want.to_st,
                 want.last, want.pad);
        $display("%0t %s: actual   key %0d moved %0b from %0d to %0d last %0b pad %0d",
                 $time, what, got.key_id, got.moved, got.from_st, got.to_st,
                 got.last, got.pad);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_beat_t got;
        result_beat_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < KEY_COUNT; k++)
            begin
                key_mode[k] = MODE_IDLE;
                key_th[k]   = KIND_BASIC;
                key_due[k]  = '0;
            end
            ms_now      = '0;
            hold_win    = HOLD_RESET;
            gap_win     = GAP_RESET;
            second_win  = SECOND_RESET;
            transitions_q.delete();
            mismatches  = 0;
        end
        else
        begin
            // results first: they always belong to items accepted earlier
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata, m_axis_tlast};
                if (transitions_q.size() == 0)
                    report("result beat with nothing pending", '0, got);
                else
                begin
                    want = transitions_q.pop_front();
                    if (got !== want)
                        report("result beat mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HOLD:   hold_win   = cfg_data;
                    REG_GAP:    gap_win    = cfg_data;
                    REG_SECOND: second_win = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_transitions(s_axis_tuser, s_axis_tdata);
        end
        outstanding = transitions_q.size();
    end

endmodule

// ----- tb/tap_hold_key_recognizer_top_tb.sv -----
module tap_hold_key_recognizer_top_tb;

    import thk_pkg::*;
    import thk_tb_pkg::*;

    localparam int KEY_COUNT    = 64;
    // Watchdog bound for the slowest run: ~240 items, a tick walks all
    // KEY_COUNT keys plus up to 64 stalled result beats.
    localparam int LIMIT_CYCLES = 600000;
    localparam int IDLE_PCT     = 33;
    // Long receiver hold-off once this many beats went in
    localparam int HOLD_OFF_AT  = 40;
    localparam int HOLD_OFF_LEN = 400;
    // Stretch of items with no idling on either side
    localparam int CALM_FROM    = 150;
    localparam int CALM_TO      = 200;

    // write to a register index the block does not have: must be ignored
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = ITEM_KEY;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index     = REG_HOLD;
    logic [15:0] cfg_data      = '0;

    int   items_sent = 0;
    int   cycles     = 0;
    int   mismatches;
    int   outstanding;
    logic calm;

    assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

    always #1 clk = ~clk;

    tap_hold_key_recognizer_top #(
        .KEY_COUNT(KEY_COUNT)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Watches all three channels, predicts each result beat and compares
    thk_checker #(
        .KEY_COUNT(KEY_COUNT)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    // Watchdog: a hung handshake or a missing result beat ends up here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off while the sender keeps
    // offering beats so the block backs up into its input, and a stretch
    // with no stalls at all.
    initial
    begin : result_sink
        bit held_off;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held_off && items_sent >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge clk);
        end
    end

    // One input beat; idles at random beforehand, then holds tvalid until
    // accepted. tvalid stays high across back-to-back beats.
    task automatic send_item(input logic [0:0] func, input logic [7:0] d);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic key_event(input int k, input press_t p, input logic kind);
        key_beat_t ev;
        ev.key_index = k[KEY_W-1:0];
        ev.pressed   = (p == PRESS_DOWN);
        ev.kind      = kind;
        send_item(ITEM_KEY, ev);
    endtask

    // tick payload is don't-care: fill it with noise
    task automatic send_tick();
        send_item(ITEM_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Wait until every predicted beat has come out, then let the block settle.
    // It first waits for the clock so the checker has seen the last accepted beat.
    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [WIN_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Reprogram all windows once the block is idle; cfg_valid stays high
    // across the writes and drops after the last one.
    task automatic set_windows(input logic [WIN_W-1:0] hold_ms,
                               input logic [WIN_W-1:0] gap_ms,
                               input logic [WIN_W-1:0] second_ms);
        drain(4);
        cfg_write(REG_UNUSED, WIN_W'($urandom_range(0, 65535)));
        cfg_write(REG_HOLD, hold_ms);
        cfg_write(REG_GAP, gap_ms);
        cfg_write(REG_SECOND, second_ms);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ticks and press/release on a few keys so they walk the whole
    // tap-hold machine; some noise beats on any key with any kind.
    task automatic random_traffic(input int items, input int pool_size);
        int pool [8];
        int i;
        int r;
        for (i = 0; i < 8; i++)
            pool[i] = $urandom_range(0, KEY_COUNT - 1);
        for (i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_tick();
            else if (r < 90)
                key_event(pool[$urandom_range(0, pool_size - 1)],
                          $urandom_range(0, 1) ? PRESS_DOWN : PRESS_RELEASE,
                          ($urandom_range(0, 99) < 80) ? KIND_TAP_HOLD : KIND_BASIC);
            else
                send_item(ITEM_KEY, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : stimulus
        int k;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset windows (200/50/150) ---
        send_tick();                                    // tick, nothing expires
        key_event(0, PRESS_DOWN, KIND_BASIC);           // basic idle -> tap
        key_event(0, PRESS_DOWN, KIND_TAP_HOLD);        // kind ignored when not idle
        key_event(0, PRESS_RELEASE, KIND_BASIC);        // basic tap -> idle
        key_event(63, PRESS_RELEASE, KIND_BASIC);       // event with no transition
        key_event(63, PRESS_DOWN, KIND_TAP_HOLD);       // idle -> tap
        key_event(63, PRESS_RELEASE, KIND_TAP_HOLD);    // tap -> gap
        key_event(63, PRESS_DOWN, KIND_BASIC);          // gap -> tap-hold
        key_event(63, PRESS_DOWN, KIND_BASIC);          // no move in tap-hold
        key_event(63, PRESS_RELEASE, KIND_BASIC);       // tap-hold -> idle

        // --- directed, minimum windows: expiries on ticks ---
        set_windows(16'd1, 16'd1, 16'd1);
        key_event(21, PRESS_DOWN, KIND_TAP_HOLD);
        key_event(42, PRESS_DOWN, KIND_TAP_HOLD);
        send_tick();                                    // deadline reached, not passed
        send_tick();                                    // two tap -> hold in one tick
        key_event(21, PRESS_RELEASE, KIND_BASIC);       // hold -> idle
        key_event(42, PRESS_RELEASE, KIND_BASIC);
        key_event(7, PRESS_DOWN, KIND_TAP_HOLD);
        key_event(7, PRESS_RELEASE, KIND_TAP_HOLD);     // tap -> gap
        send_tick();
        send_tick();                                    // gap -> second-tap wait
        send_tick();
        send_tick();                                    // second-tap wait -> idle

        // --- whole matrix pressed, then one tick expires every tap-hold key ---
        for (k = 0; k < KEY_COUNT; k++)
            key_event(k, PRESS_DOWN,
                      ($urandom_range(0, 99) < 85) ? KIND_TAP_HOLD : KIND_BASIC);
        send_tick();
        send_tick();
        for (k = 0; k < KEY_COUNT; k++)
            key_event(k, PRESS_RELEASE, 1'($urandom_range(0, 1)));

        // zero windows: a deadline passes on the very next tick
        set_windows(16'd0, 16'd0, 16'd0);
        random_traffic(15, 4);

        // maximum windows: no newly set deadline can expire here
        set_windows(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_traffic(10, 8);

        // short random windows, small key pools for deep sequences
        for (n = 0; n < 3; n++)
        begin
            set_windows(WIN_W'($urandom_range(1, 4)), WIN_W'($urandom_range(1, 4)),
                        WIN_W'($urandom_range(1, 6)));
            random_traffic(20, $urandom_range(2, 8));
        end

        drain(KEY_COUNT + 8);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/thk_pkg.sv
rtl/thk_ctrl.sv
rtl/thk_datapath.sv
rtl/tap_hold_key_recognizer_top.sv
tb/thk_tb_pkg.sv
tb/thk_checker.sv
tb/tap_hold_key_recognizer_top_tb.sv
